>>> rtl/uopf_pkg.sv
// shared types and constants of the utf-8 overlong packet filter
`default_nettype none

package uopf_pkg;

	// width of the saturating per-packet byte counter
	localparam int COUNT_BITS = 8;
	localparam int SKIP_BITS  = 8;
	// compare width that holds both the count and the header skip
	localparam int CMP_BITS   = (COUNT_BITS > SKIP_BITS) ? COUNT_BITS : SKIP_BITS;

	localparam int BYTE_BITS   = 8;
	localparam int REASON_BITS = 3;

	// configuration port
	localparam int CFG_INDEX_BITS = 1;
	localparam int CFG_DATA_BITS  = 8;

	localparam logic [CFG_INDEX_BITS-1:0] CFG_HEADER_SKIP       = 1'd0;
	localparam logic [CFG_INDEX_BITS-1:0] CFG_DROP_ON_TRUNCATED = 1'd1;

	localparam logic [SKIP_BITS-1:0] HEADER_SKIP_RESET       = 8'd1;
	localparam logic                 DROP_ON_TRUNCATED_RESET = 1'b1;

	// lead bytes and continuation prefixes
	localparam logic [BYTE_BITS-1:0] BYTE_C0 = 8'hC0;
	localparam logic [BYTE_BITS-1:0] BYTE_C1 = 8'hC1;
	localparam logic [BYTE_BITS-1:0] BYTE_E0 = 8'hE0;
	localparam logic [BYTE_BITS-1:0] BYTE_F0 = 8'hF0;
	// E0 overlong second byte is 80..9F, F0 overlong second byte is 80..8F
	localparam logic [2:0] E0_LOW_PREFIX = 3'b100;
	localparam logic [3:0] F0_LOW_PREFIX = 4'b1000;

	typedef enum logic [1:0] {
		LEAD_NONE = 2'd0,
		LEAD_E0   = 2'd1,
		LEAD_F0   = 2'd2
	} lead_t;

	typedef enum logic [REASON_BITS-1:0] {
		REASON_CLEAN = 3'd0,
		REASON_TWO   = 3'd1,
		REASON_THREE = 3'd2,
		REASON_FOUR  = 3'd3,
		REASON_TRUNC = 3'd4
	} reason_t;

	// per-packet scan state
	typedef struct packed {
		logic [COUNT_BITS-1:0] count;
		lead_t                 lead;
		logic                  bad;
		reason_t               why;
	} scan_state_t;

	// configuration seen by the checker
	typedef struct packed {
		logic [SKIP_BITS-1:0] header_skip;
		logic                 drop_on_truncated;
	} filter_cfg_t;

	// verdict produced for a last byte
	typedef struct packed {
		logic    forward;
		reason_t reason;
	} verdict_t;

endpackage

`default_nettype wire

>>> rtl/uopf_if.sv
// channel interfaces of the utf-8 overlong packet filter
`default_nettype none

interface uopf_byte_if import uopf_pkg::*; ();
	logic                 valid;
	logic                 ready;
	logic [BYTE_BITS-1:0] data_byte;
	logic                 last_byte;

	modport source (output valid, output data_byte, output last_byte, input ready);
	modport sink   (input valid, input data_byte, input last_byte, output ready);
endinterface

interface uopf_verdict_if import uopf_pkg::*; ();
	logic                   valid;
	logic                   ready;
	logic                   forward;
	logic [REASON_BITS-1:0] reason;

	modport source (output valid, output forward, output reason, input ready);
	modport sink   (input valid, input forward, input reason, output ready);
endinterface

interface uopf_cfg_if import uopf_pkg::*; ();
	logic                      valid;
	logic                      ready;
	logic [CFG_INDEX_BITS-1:0] index;
	logic [CFG_DATA_BITS-1:0]  data;

	modport source (output valid, output index, output data, input ready);
	modport sink   (input valid, input index, input data, output ready);
endinterface

`default_nettype wire

>>> rtl/uopf_check.sv
// per-byte overlong check: next scan state and verdict for one byte
`default_nettype none

module uopf_check import uopf_pkg::*; (
	input  scan_state_t          cur,
	input  filter_cfg_t          cfg,
	input  logic [BYTE_BITS-1:0] data_byte,
	input  logic                 last_byte,
	output scan_state_t          nxt,
	output verdict_t             verdict
);

	logic                checked;
	logic [CMP_BITS-1:0] pos_ext;
	logic [CMP_BITS-1:0] skip_ext;
	scan_state_t         scan;

	assign pos_ext  = CMP_BITS'(cur.count);
	assign skip_ext = CMP_BITS'(cfg.header_skip);
	assign checked  = !cur.bad && (pos_ext >= skip_ext);

	always_comb begin
		scan       = cur;
		scan.count = (&cur.count) ? cur.count : cur.count + 1'b1;
		if (checked) begin
			scan.lead = LEAD_NONE;
			priority if (cur.lead == LEAD_E0 && data_byte[7:5] == E0_LOW_PREFIX) begin
				scan.bad = 1'b1;
				scan.why = REASON_THREE;
			end else if (cur.lead == LEAD_F0 && data_byte[7:4] == F0_LOW_PREFIX) begin
				scan.bad = 1'b1;
				scan.why = REASON_FOUR;
			end else if (data_byte == BYTE_C0 || data_byte == BYTE_C1) begin
				scan.bad = 1'b1;
				scan.why = REASON_TWO;
			end else if (data_byte == BYTE_E0) begin
				scan.lead = LEAD_E0;
			end else if (data_byte == BYTE_F0) begin
				scan.lead = LEAD_F0;
			end else begin
				// any other byte leaves no lead pending
				scan.lead = LEAD_NONE;
			end
		end
	end

	always_comb begin
		priority if (scan.bad) begin
			verdict.forward = 1'b0;
			verdict.reason  = scan.why;
		end else if (scan.lead != LEAD_NONE && cfg.drop_on_truncated) begin
			verdict.forward = 1'b0;
			verdict.reason  = REASON_TRUNC;
		end else begin
			verdict.forward = 1'b1;
			verdict.reason  = REASON_CLEAN;
		end
	end

	// a last byte closes the packet and clears the scan state
	always_comb begin
		if (last_byte) begin
			nxt = '{count: '0, lead: LEAD_NONE, bad: 1'b0, why: REASON_CLEAN};
		end else begin
			nxt = scan;
		end
	end

endmodule

`default_nettype wire

>>> rtl/utf8_overlong_packet_filter.sv
// top level of the utf-8 overlong packet filter
// a last byte's verdict passes through the input stage, then the result register, before it is valid
// throughput: one byte per cycle (single input stage and result register) unless a last byte is held back
// the byte stage advances unless it holds a last byte and the result register is full and not being taken
// reset: arst_n clears scan state, the input stage valid and the result register valid at once
// reset sets header_skip to 1 and drop_on_truncated to 1
`default_nettype none

module utf8_overlong_packet_filter import uopf_pkg::*; (
	input  logic          clk,
	input  logic          arst_n,
	uopf_cfg_if.sink      cfg,
	uopf_byte_if.sink     bytes,
	uopf_verdict_if.source verdict
);

	// configuration registers
	filter_cfg_t cfg_q;

	// input stage
	logic                 valid_s1;
	logic [BYTE_BITS-1:0] data_s1;
	logic                 last_s1;

	// scan state carried between bytes of a packet
	scan_state_t state_q;
	scan_state_t state_nxt;
	verdict_t    verdict_nxt;

	// result register
	logic     out_valid_q;
	verdict_t out_q;

	logic advance;

	// configuration writes are always taken
	assign cfg.ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.header_skip       <= HEADER_SKIP_RESET;
			cfg_q.drop_on_truncated <= DROP_ON_TRUNCATED_RESET;
		end else if (cfg.valid) begin
			unique case (cfg.index)
				CFG_HEADER_SKIP:       cfg_q.header_skip <= cfg.data;
				CFG_DROP_ON_TRUNCATED: cfg_q.drop_on_truncated <= cfg.data[0];
				default: ;
			endcase
		end
	end

	// the staged byte moves on unless it is a last byte facing a full result register that is not being taken
	assign advance     = valid_s1 && (!last_s1 || !out_valid_q || verdict.ready);
	assign bytes.ready = !valid_s1 || advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (bytes.ready) begin
			valid_s1 <= bytes.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (bytes.ready && bytes.valid) begin
			data_s1 <= bytes.data_byte;
			last_s1 <= bytes.last_byte;
		end
	end

	uopf_check u_check (
		.cur       (state_q),
		.cfg       (cfg_q),
		.data_byte (data_s1),
		.last_byte (last_s1),
		.nxt       (state_nxt),
		.verdict   (verdict_nxt)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= '{count: '0, lead: LEAD_NONE, bad: 1'b0, why: REASON_CLEAN};
		end else if (advance) begin
			state_q <= state_nxt;
		end
	end

	// result register: loaded by a last byte, emptied by the downstream transaction
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (advance && last_s1) begin
			out_valid_q <= 1'b1;
		end else if (verdict.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance && last_s1) begin
			out_q <= verdict_nxt;
		end
	end

	assign verdict.valid   = out_valid_q;
	assign verdict.forward = out_q.forward;
	assign verdict.reason  = out_q.reason;

	// a found offence leaves no lead pending
	a_bad_no_lead: assert property (@(posedge clk) disable iff (!arst_n)
		state_q.bad |-> state_q.lead == LEAD_NONE)
		else $error("lead pending after offence");

	// a forwarded packet always reports clean
	a_forward_clean: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q && out_q.forward |-> out_q.reason == REASON_CLEAN)
		else $error("forwarded packet with nonzero reason");

	// a dropped packet always carries a reason
	a_drop_reason: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q && !out_q.forward |->
			(out_q.reason == REASON_TWO || out_q.reason == REASON_THREE ||
			 out_q.reason == REASON_FOUR || out_q.reason == REASON_TRUNC))
		else $error("dropped packet without valid reason");

	// closing a packet clears its scan state and fills the result register
	a_close_clears: assert property (@(posedge clk) disable iff (!arst_n)
		advance && last_s1 |=> state_q.count == '0 && !state_q.bad && out_valid_q)
		else $error("packet state not cleared on last byte");

	// a full result register that is not taken blocks a staged last byte
	a_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q && !verdict.ready && valid_s1 && last_s1 |-> !advance)
		else $error("result register overwritten");

endmodule

`default_nettype wire
